// ----- sv/kmsd_pkg.sv -----
package kmsd_pkg;

  // Matrix geometry
  localparam int ROWS = 4;
  localparam int COLS = 4;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Field widths
  localparam int COL_W      = 4;
  localparam int DRIVE_W    = 4;
  localparam int KEYS_W     = 16;
  localparam int SETTLE_W   = 8;
  localparam int DEBOUNCE_W = 16;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Stream packing
  localparam int S_TDATA_W = ((COL_W + 7) / 8) * 8;
  localparam int M_PAYLOAD_W = DRIVE_W + 2 * KEYS_W;
  localparam int M_TDATA_W = ((M_PAYLOAD_W + 7) / 8) * 8;
  localparam int M_TUSER_W = 1;
  localparam int RELEASED_LSB = DRIVE_W;
  localparam int SCAN_LSB     = DRIVE_W + KEYS_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

  // Reset values
  localparam logic [SETTLE_W-1:0]   SETTLE_RST   = 8'd1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETTLE
  } phase_t;

  typedef struct packed {
    logic [SETTLE_W-1:0]   settle_ticks;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [INTERVAL_W-1:0] scan_interval_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] row_drive;
    logic               release_valid;
    logic [KEYS_W-1:0]  released_keys;
    logic [KEYS_W-1:0]  current_scan;
  } result_t;

endpackage

// ----- sv/keypad_matrix_scan_debounce_core.sv -----
// Keypad matrix scanner with release debounce (4 rows by 4 columns).
//
// Input stream (s_*): one beat per time tick, carrying the sampled column
// levels; a low bit means the key on that column is closed.
// Output stream (m_*): exactly one beat per input beat, in order, with the
// row drive pattern for that tick, a release event flag with the released
// key mask, and the mask found by the last complete scan.
// Config port: cfg_we writes cfg_data to register cfg_index in the same
// cycle (0 settle ticks, 1 debounce ticks, 2 scan interval ticks); other
// indexes are dropped. Write only while no beat is in flight.
//
// Path: input register, then the scan step logic into the output register.
// Throughput: one beat per cycle while the output is not stalled; the scan
// state register updates once per beat in the step stage.
// Reset (rst, synchronous): both stages empty, sequencer idle, counters and
// key masks cleared, registers back to 1 / 50 / 10.
// Output stall: the output register holds its beat; the input register
// fills behind it, and s_tready drops only when both are full.
module keypad_matrix_scan_debounce_core (
  input  logic                            clk,
  input  logic                            rst,
  // config write port
  input  logic                            cfg_we,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmsd_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kmsd_pkg::S_TDATA_W-1:0]  s_tdata,   // [3:0] column_levels
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] row_drive, [19:4] released_keys, [35:20] current_scan
  output logic [kmsd_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [kmsd_pkg::M_TUSER_W-1:0]  m_tuser    // [0] release_valid
);

  kmsd_pkg::cfg_t              cfg;
  kmsd_pkg::result_t           res;
  logic                        out_ready;
  logic                        in_valid;
  logic [kmsd_pkg::COL_W-1:0]  in_cols;
  logic                        advance;

  // step stage moves a beat on when the output register can take it
  assign advance = in_valid && out_ready;

  kmsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kmsd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .out_ready (out_ready),
    .in_valid  (in_valid),
    .in_cols   (in_cols)
  );

  kmsd_scan_step u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .in_cols (in_cols),
    .res     (res)
  );

  kmsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res       (res),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- sv/kmsd_cfg_regs.sv -----
module kmsd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kmsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output kmsd_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks        <= kmsd_pkg::SETTLE_RST;
      cfg.debounce_ticks      <= kmsd_pkg::DEBOUNCE_RST;
      cfg.scan_interval_ticks <= kmsd_pkg::INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmsd_pkg::REG_SETTLE:
          cfg.settle_ticks <= cfg_data[kmsd_pkg::SETTLE_W-1:0];
        kmsd_pkg::REG_DEBOUNCE:
          cfg.debounce_ticks <= cfg_data[kmsd_pkg::DEBOUNCE_W-1:0];
        kmsd_pkg::REG_INTERVAL:
          cfg.scan_interval_ticks <= cfg_data[kmsd_pkg::INTERVAL_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

endmodule

// ----- sv/kmsd_in_stage.sv -----
module kmsd_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kmsd_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          out_ready,
  output logic                          in_valid,
  output logic [kmsd_pkg::COL_W-1:0]    in_cols
);

  logic s_fire;

  assign s_tready = !in_valid || out_ready;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (out_ready) begin
      in_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_cols <= s_tdata[kmsd_pkg::COL_W-1:0];
    end
  end

endmodule

// ----- sv/kmsd_scan_step.sv -----
module kmsd_scan_step (
  input  logic                       clk,
  input  logic                       rst,
  input  kmsd_pkg::cfg_t             cfg,
  input  logic                       advance,
  input  logic [kmsd_pkg::COL_W-1:0] in_cols,
  output kmsd_pkg::result_t          res
);

  kmsd_pkg::phase_t                  phase, phase_next;
  logic [kmsd_pkg::ROW_W-1:0]        row_index, row_index_next;
  logic [kmsd_pkg::SETTLE_W-1:0]     settle_count, settle_count_next;
  logic [kmsd_pkg::INTERVAL_W-1:0]   interval_count, interval_count_next;
  logic [kmsd_pkg::KEYS_W-1:0]       scan_accum, scan_accum_next;
  logic [kmsd_pkg::KEYS_W-1:0]       held_keys, held_keys_next;
  logic [kmsd_pkg::DEBOUNCE_W-1:0]   debounce_count, debounce_count_next;
  logic [kmsd_pkg::KEYS_W-1:0]       last_scan, last_scan_next;

  logic [kmsd_pkg::DEBOUNCE_W-1:0]   dc_dec;
  logic [kmsd_pkg::INTERVAL_W-1:0]   ic_inc;
  logic [kmsd_pkg::SETTLE_W-1:0]     sc_inc;
  logic [kmsd_pkg::COLS-1:0]         pressed;
  logic [kmsd_pkg::KEYS_W-1:0]       accum_or;
  logic                              last_row;

  assign dc_dec  = (debounce_count != '0) ? debounce_count - 1'b1 : debounce_count;
  assign ic_inc  = interval_count + 1'b1;
  assign sc_inc  = settle_count + 1'b1;
  assign pressed = ~in_cols[kmsd_pkg::COLS-1:0];
  assign last_row = (row_index == kmsd_pkg::ROW_W'(kmsd_pkg::ROWS - 1));

  // key bit k belongs to row k/COLS, column k%COLS; bits past the matrix stay clear
  always_comb begin
    for (int k = 0; k < kmsd_pkg::KEYS_W; k++) begin
      if (k / kmsd_pkg::COLS < kmsd_pkg::ROWS) begin
        accum_or[k] = scan_accum[k] ||
                      ((row_index == kmsd_pkg::ROW_W'(k / kmsd_pkg::COLS)) &&
                       pressed[k % kmsd_pkg::COLS]);
      end else begin
        accum_or[k] = scan_accum[k];
      end
    end
  end

  always_comb begin
    phase_next          = phase;
    row_index_next      = row_index;
    settle_count_next   = settle_count;
    interval_count_next = interval_count;
    scan_accum_next     = scan_accum;
    held_keys_next      = held_keys;
    debounce_count_next = dc_dec;
    last_scan_next      = last_scan;
    res.release_valid   = 1'b0;
    res.released_keys   = '0;

    for (int r = 0; r < kmsd_pkg::DRIVE_W; r++) begin
      res.row_drive[r] = !((phase == kmsd_pkg::PH_SETTLE) &&
                           (r < kmsd_pkg::ROWS) &&
                           (row_index == kmsd_pkg::ROW_W'(r)));
    end

    unique case (phase)
      kmsd_pkg::PH_IDLE: begin
        interval_count_next = ic_inc;
        if (ic_inc >= cfg.scan_interval_ticks) begin
          interval_count_next = '0;
          phase_next          = kmsd_pkg::PH_SETTLE;
          row_index_next      = '0;
          settle_count_next   = '0;
          scan_accum_next     = '0;
        end
      end
      kmsd_pkg::PH_SETTLE: begin
        settle_count_next = sc_inc;
        if (sc_inc >= cfg.settle_ticks) begin
          settle_count_next = '0;
          scan_accum_next   = accum_or;
          row_index_next    = row_index + 1'b1;
          if (last_row) begin
            if (accum_or != '0) begin
              if (accum_or != held_keys) debounce_count_next = cfg.debounce_ticks;
              held_keys_next = held_keys | accum_or;
            end else begin
              if (held_keys != '0 && dc_dec == '0) begin
                res.release_valid = 1'b1;
                res.released_keys = held_keys;
              end
              held_keys_next = '0;
            end
            last_scan_next      = accum_or;
            row_index_next      = '0;
            phase_next          = kmsd_pkg::PH_IDLE;
            interval_count_next = '0;
          end
        end
      end
      default: phase_next = kmsd_pkg::PH_IDLE;
    endcase

    res.current_scan = last_scan_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= kmsd_pkg::PH_IDLE;
      row_index      <= '0;
      settle_count   <= '0;
      interval_count <= '0;
      scan_accum     <= '0;
      held_keys      <= '0;
      debounce_count <= '0;
      last_scan      <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      row_index      <= row_index_next;
      settle_count   <= settle_count_next;
      interval_count <= interval_count_next;
      scan_accum     <= scan_accum_next;
      held_keys      <= held_keys_next;
      debounce_count <= debounce_count_next;
      last_scan      <= last_scan_next;
    end
  end

endmodule

// ----- sv/kmsd_out_stage.sv -----
module kmsd_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  kmsd_pkg::result_t               res,
  output logic                            out_ready,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kmsd_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [kmsd_pkg::M_TUSER_W-1:0]  m_tuser
);

  kmsd_pkg::result_t held;

  assign out_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= res;
    end
  end

  assign m_tdata = kmsd_pkg::M_TDATA_W'({held.current_scan, held.released_keys,
                                         held.row_drive});
  assign m_tuser = held.release_valid;

endmodule

// ----- sv/kmsd_checker.sv -----
module kmsd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kmsd_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [kmsd_pkg::M_TUSER_W-1:0]  m_tuser
);

  logic [kmsd_pkg::DRIVE_W-1:0] drive;
  logic [kmsd_pkg::KEYS_W-1:0]  rel_keys;

  assign drive    = m_tdata[kmsd_pkg::DRIVE_W-1:0];
  assign rel_keys = m_tdata[kmsd_pkg::RELEASED_LSB +: kmsd_pkg::KEYS_W];

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat present after reset");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  // at most one row driven low per tick
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(~drive))
    else $error("more than one row driven low");

  // a release event carries a nonzero mask
  a_release_mask: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> rel_keys != '0)
    else $error("release event with empty key mask");

  // no release event, no mask
  a_no_release_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> rel_keys == '0)
    else $error("released keys set without release event");

endmodule

bind keypad_matrix_scan_debounce_core kmsd_checker u_kmsd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
